// ----- rtl/bldq_pkg.sv -----
// ----------------------------------------------------------------------------
// bldq_pkg
// Shared types, sizes and codes for the bounded list deque with delete.
// ----------------------------------------------------------------------------
package bldq_pkg;

	// Number of entries the list can hold.
	localparam int DEPTH = 16;

	// Width of the internal entry count (holds 0 to DEPTH inclusive).
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Width of an index into the row of cells.
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Field widths fixed by the item formats.
	localparam int OPCODE_W      = 3;
	localparam int VALUE_W       = 32;
	localparam int STATUS_W      = 2;
	localparam int ENTRY_COUNT_W = 5;

	// Opcodes.
	localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_DELETE     = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd5;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Input item.
	typedef struct packed {
		logic [OPCODE_W-1:0]       opcode;
		logic signed [VALUE_W-1:0] value;
	} item_t;

	// Result item.
	typedef struct packed {
		logic signed [VALUE_W-1:0] popped_value;
		logic                      found;
		logic [STATUS_W-1:0]       status;
		logic [ENTRY_COUNT_W-1:0]  entry_count;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;  // capture the incoming item
		logic exec;  // apply the captured item to the list
	} cmd_t;

endpackage

// ----- rtl/bounded_list_deque_with_delete_core.sv -----
// ----------------------------------------------------------------------------
// bounded_list_deque_with_delete_core
// Bounded ordered list of signed values with push, pop, delete and search.
// ----------------------------------------------------------------------------
// Usage:
// An item (opcode and value) is taken at a rising clock edge where start is
// high and busy is low. Busy is high for the single execute cycle that
// follows; during it every cell of the row compares its entry with the
// value, the frontmost match is found, and the row shifts by one place
// where the operation asks for it (for a delete, only from the match back).
// Every item yields exactly one result item. It appears on result with done
// high for exactly one cycle, starting at the clock edge that ends the
// execute cycle, when the result is registered. Busy falls as done rises,
// so a new item may be offered in the strobe cycle; no new item is taken
// while busy is high.
// The receiver cannot hold results off; it must take each one in its cycle.
// Reset (arst_n low) empties the list and clears the controller; the entry
// cells themselves are not cleared, since an entry is only read once it has
// been written by a push.
// ----------------------------------------------------------------------------
module bounded_list_deque_with_delete_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bldq_pkg::item_t   item,
	output logic              done,
	output bldq_pkg::result_t result
);

	// Commands from the sequencer to the cell row.
	bldq_pkg::cmd_t cmd;

	bldq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// The row of cells holds the list, front at cell zero, plus the count
	// and the registered result.
	bldq_cell_row u_cell_row (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

endmodule

// ----- rtl/bldq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bldq_ctrl
// Sequencer: accepts an item, runs one execute cycle, then strobes the result.
// ----------------------------------------------------------------------------
module bldq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output bldq_pkg::cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	assign busy = (state_q == S_EXEC);
	assign done = done_q;

endmodule

// ----- rtl/bldq_cell_row.sv -----
// ----------------------------------------------------------------------------
// bldq_cell_row
// Datapath: a row of entry cells with parallel compare and one-step shifts.
// ----------------------------------------------------------------------------
module bldq_cell_row (
	input  logic              clk,
	input  logic              arst_n,
	input  bldq_pkg::cmd_t    cmd,
	input  bldq_pkg::item_t   item,
	output bldq_pkg::result_t result
);

	logic signed [bldq_pkg::VALUE_W-1:0] ent_q [bldq_pkg::DEPTH];
	logic signed [bldq_pkg::VALUE_W-1:0] ent_d [bldq_pkg::DEPTH];
	logic [bldq_pkg::CNT_W-1:0]          count_q;
	logic [bldq_pkg::CNT_W-1:0]          count_d;
	logic [bldq_pkg::CNT_W-1:0]          back_pos;
	logic [bldq_pkg::IDX_W-1:0]          back_idx;
	logic [bldq_pkg::DEPTH-1:0]          match;
	logic [bldq_pkg::DEPTH-1:0]          first_hot;
	logic [bldq_pkg::DEPTH-1:0]          from_hit;
	logic                                any_hit;
	logic                                full;
	logic                                empty;
	bldq_pkg::item_t                     item_q;
	bldq_pkg::result_t                   result_q;
	bldq_pkg::result_t                   result_d;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	// Each cell compares against the held value; only live cells may match.
	always_comb begin
		for (int i = 0; i < bldq_pkg::DEPTH; i++) begin
			match[i] = (bldq_pkg::CNT_W'(i) < count_q) && (ent_q[i] == item_q.value);
		end
	end

	// Isolate the frontmost hit and mark every cell from it to the back.
	assign first_hot = match & (~match + 1'b1);
	assign from_hit  = ~(first_hot - 1'b1);
	assign any_hit   = |match;

	assign full     = (count_q == bldq_pkg::CNT_W'(bldq_pkg::DEPTH));
	assign empty    = (count_q == '0);
	assign back_pos = count_q - 1'b1;
	assign back_idx = back_pos[bldq_pkg::IDX_W-1:0];

	always_comb begin
		for (int i = 0; i < bldq_pkg::DEPTH; i++) begin
			ent_d[i] = ent_q[i];
		end
		count_d               = count_q;
		result_d.popped_value = '0;
		result_d.found        = 1'b0;
		result_d.status       = bldq_pkg::ST_OK;

		unique case (item_q.opcode)
			bldq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					result_d.status = bldq_pkg::ST_FULL;
				end else begin
					ent_d[0] = item_q.value;
					for (int i = 1; i < bldq_pkg::DEPTH; i++) begin
						ent_d[i] = ent_q[i-1];
					end
					count_d = count_q + 1'b1;
				end
			end
			bldq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					result_d.status = bldq_pkg::ST_FULL;
				end else begin
					for (int i = 0; i < bldq_pkg::DEPTH; i++) begin
						if (bldq_pkg::CNT_W'(i) == count_q) begin
							ent_d[i] = item_q.value;
						end
					end
					count_d = count_q + 1'b1;
				end
			end
			bldq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					result_d.status = bldq_pkg::ST_EMPTY;
				end else begin
					result_d.popped_value = ent_q[0];
					for (int i = 0; i < bldq_pkg::DEPTH - 1; i++) begin
						ent_d[i] = ent_q[i+1];
					end
					count_d = count_q - 1'b1;
				end
			end
			bldq_pkg::OP_POP_BACK: begin
				if (empty) begin
					result_d.status = bldq_pkg::ST_EMPTY;
				end else begin
					result_d.popped_value = ent_q[back_idx];
					count_d               = count_q - 1'b1;
				end
			end
			bldq_pkg::OP_DELETE: begin
				result_d.found = any_hit;
				if (any_hit) begin
					for (int i = 0; i < bldq_pkg::DEPTH - 1; i++) begin
						if (from_hit[i]) begin
							ent_d[i] = ent_q[i+1];
						end
					end
					count_d = count_q - 1'b1;
				end
			end
			bldq_pkg::OP_SEARCH: begin
				result_d.found = any_hit;
			end
			default: begin
			end
		endcase

		result_d.entry_count = bldq_pkg::ENTRY_COUNT_W'(count_d);
	end

	// Entry cells hold payload only and carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < bldq_pkg::DEPTH; i++) begin
				ent_q[i] <= ent_d[i];
			end
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	assign result = result_q;

endmodule

// ----- tb/bounded_list_deque_with_delete_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_deque_with_delete_core_tb
// Self-checking bench for the bounded list deque with push, pop, delete and
// search. A short table of directed items covers the empty and full list,
// an unused opcode and the single-entry cases. Several random phases follow,
// each with an opcode mix and idle rate from a table. Every result is checked
// field by field against its typed table row, else a behavioural list model.
// ----------------------------------------------------------------------------
module bounded_list_deque_with_delete_core_tb;

	// The block has no cases for these two codes. They must act as a no-op
	// that still reports the count.
	localparam logic [bldq_pkg::OPCODE_W-1:0] OP_UNUSED_LO = 3'd6;
	localparam logic [bldq_pkg::OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

	localparam int PHASE_ITEMS = 150;
	localparam int NUM_PHASES  = 7;
	// This limit on cycles without any handshake is many times the longest
	// sender gap plus the time that the core takes to answer an item.
	localparam int STALL_LIMIT = 500;

	// Each random phase pushes the list towards one region of its behaviour.
	typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_HUNT} mix_e;

	// One row of the directed table. The row can carry an expected result
	// typed in by hand. Without one, the model supplies the expectation.
	typedef struct {
		logic [bldq_pkg::OPCODE_W-1:0] opcode;
		logic signed [31:0]            value;
		int unsigned                   reps;
		bit                            typed;
		bldq_pkg::result_t             want;
	} drow_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	bldq_pkg::item_t   item = '0;
	logic              done;
	bldq_pkg::result_t result;

	// Typed expectation that travels with the item on offer.
	bit                typed_valid = 1'b0;
	bldq_pkg::result_t typed_want = '0;

	// Model of the list: front at index 0, valid below list_len.
	logic signed [bldq_pkg::VALUE_W-1:0] list_mem [bldq_pkg::DEPTH];
	int unsigned                         list_len = 0;

	bldq_pkg::result_t pending_q [$];
	int unsigned       fail_count = 0;
	int unsigned       stall_cycles = 0;

	// Values that match one another often, so that delete and search hit.
	logic signed [31:0] value_pool [8] = '{32'sd0, -32'sd1, 32'sd1, 32'sh8000_0000,
		32'sh7FFF_FFFF, 32'sh5A5A_A5A5, 32'sd42, -32'sd42};

	// Opcode weights per mix, indexed by opcode, the two unused codes last.
	int unsigned op_weight [4][8] = '{
		'{30, 30, 8, 8, 8, 10, 3, 3},
		'{16, 16, 16, 16, 14, 16, 3, 3},
		'{6, 6, 34, 34, 10, 6, 2, 2},
		'{14, 14, 6, 6, 30, 26, 2, 2}
	};

	mix_e        phase_mix [NUM_PHASES] = '{MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_FILL,
		MIX_HUNT, MIX_DRAIN, MIX_BALANCED};
	// The first phase and the last run without any sender gaps.
	int unsigned phase_idle_pct [NUM_PHASES] = '{0, 25, 10, 40, 15, 30, 0};

	drow_t directed_rows [14] = '{
		'{bldq_pkg::OP_POP_FRONT, 32'sd0, 1, 1'b1,
			'{32'sd0, 1'b0, bldq_pkg::ST_EMPTY, 5'd0}},
		'{bldq_pkg::OP_POP_BACK, -32'sd1, 1, 1'b1,
			'{32'sd0, 1'b0, bldq_pkg::ST_EMPTY, 5'd0}},
		'{OP_UNUSED_HI, 32'sh7FFF_FFFF, 1, 1'b1,
			'{32'sd0, 1'b0, bldq_pkg::ST_OK, 5'd0}},
		'{bldq_pkg::OP_SEARCH, 32'sd0, 1, 1'b1,
			'{32'sd0, 1'b0, bldq_pkg::ST_OK, 5'd0}},
		'{bldq_pkg::OP_PUSH_FRONT, 32'sh8000_0000, 1, 1'b1,
			'{32'sd0, 1'b0, bldq_pkg::ST_OK, 5'd1}},
		'{bldq_pkg::OP_POP_BACK, 32'sd0, 1, 1'b1,
			'{32'sh8000_0000, 1'b0, bldq_pkg::ST_OK, 5'd0}},
		'{bldq_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF, 1, 1'b1,
			'{32'sd0, 1'b0, bldq_pkg::ST_OK, 5'd1}},
		'{bldq_pkg::OP_POP_FRONT, 32'sd0, 1, 1'b1,
			'{32'sh7FFF_FFFF, 1'b0, bldq_pkg::ST_OK, 5'd0}},
		'{bldq_pkg::OP_PUSH_BACK, 32'sh5555_5555, 15, 1'b0, '0},
		'{bldq_pkg::OP_PUSH_FRONT, -32'sd1, 1, 1'b1,
			'{32'sd0, 1'b0, bldq_pkg::ST_OK, 5'd16}},
		'{bldq_pkg::OP_PUSH_BACK, 32'sd0, 1, 1'b1,
			'{32'sd0, 1'b0, bldq_pkg::ST_FULL, 5'd16}},
		'{bldq_pkg::OP_SEARCH, 32'sh5555_5555, 1, 1'b1,
			'{32'sd0, 1'b1, bldq_pkg::ST_OK, 5'd16}},
		'{bldq_pkg::OP_DELETE, -32'sd1, 1, 1'b1,
			'{32'sd0, 1'b1, bldq_pkg::ST_OK, 5'd15}},
		'{bldq_pkg::OP_DELETE, 32'sh1234_5678, 1, 1'b1,
			'{32'sd0, 1'b0, bldq_pkg::ST_OK, 5'd15}}
	};

	bounded_list_deque_with_delete_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// Close the gap left by the entry at pos. Every entry behind it moves one
	// place towards the front.
	function automatic void list_remove(int unsigned pos);
		int unsigned i;
		for (i = pos; i + 1 < list_len; i++)
			list_mem[i] = list_mem[i + 1];
		list_len--;
	endfunction

	// Apply one item to the model and return the result that it must give.
	function automatic bldq_pkg::result_t list_apply(bldq_pkg::item_t it);
		bldq_pkg::result_t r;
		int                hit;
		int unsigned       i;
		r   = '0;
		hit = -1;
		case (it.opcode) inside
			bldq_pkg::OP_PUSH_FRONT, bldq_pkg::OP_PUSH_BACK: begin
				if (list_len >= bldq_pkg::DEPTH) begin
					r.status = bldq_pkg::ST_FULL;
				end else if (it.opcode == bldq_pkg::OP_PUSH_BACK) begin
					list_mem[list_len] = it.value;
					list_len++;
				end else begin
					for (i = list_len; i > 0; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[0] = it.value;
					list_len++;
				end
			end
			bldq_pkg::OP_POP_FRONT, bldq_pkg::OP_POP_BACK: begin
				if (list_len == 0) begin
					r.status = bldq_pkg::ST_EMPTY;
				end else if (it.opcode == bldq_pkg::OP_POP_FRONT) begin
					r.popped_value = list_mem[0];
					list_remove(0);
				end else begin
					r.popped_value = list_mem[list_len - 1];
					list_len--;
				end
			end
			bldq_pkg::OP_DELETE, bldq_pkg::OP_SEARCH: begin
				// Only the frontmost match counts, which matters for delete.
				for (i = 0; i < list_len; i++)
					if (hit < 0 && list_mem[i] == it.value)
						hit = i;
				if (hit >= 0) begin
					r.found = 1'b1;
					if (it.opcode == bldq_pkg::OP_DELETE)
						list_remove(hit);
				end
			end
			default: ;
		endcase
		r.entry_count = list_len[bldq_pkg::ENTRY_COUNT_W-1:0];
		return r;
	endfunction

	// Results are checked before the item of the same edge is modelled. A
	// result can never belong to an item that is accepted at that very edge.
	always @(posedge clk) begin
		bldq_pkg::result_t want;
		bldq_pkg::result_t got;
		if (arst_n) begin
			if (done) begin
				got = result;
				if (pending_q.size() == 0) begin
					$error("result arrived with no item outstanding");
					fail_count++;
				end else begin
					want = pending_q.pop_front();
					if (got.popped_value !== want.popped_value) begin
						$error("popped_value: expected %0d, got %0d",
							want.popped_value, got.popped_value);
						fail_count++;
					end
					if (got.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, got.found);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
					if (got.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, got.entry_count);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				// The model runs on every item, so that its list stays in step
				// even where the table gives the expectation instead.
				want = list_apply(item);
				pending_q.push_back(typed_valid ? typed_want : want);
			end
		end
	end

	// Cycles with no handshake in either direction.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("bounded_list_deque_with_delete_core test failed");
		$finish;
	end

	// Offer one item from the falling edge and hold it until it is taken.
	task automatic send_item(bldq_pkg::item_t it, bit typed, bldq_pkg::result_t want);
		@(negedge clk);
		item        <= it;
		start       <= 1'b1;
		typed_valid <= typed;
		typed_want  <= want;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Leave start low for a number of cycles, with noise on the item bus.
	task automatic sender_gap(int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			item  <= '{opcode: bldq_pkg::OPCODE_W'($urandom()), value: $urandom()};
		end
	endtask

	// Hold back until every outstanding result has come back.
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [bldq_pkg::OPCODE_W-1:0] pick_opcode(mix_e mix);
		int unsigned total;
		int unsigned roll;
		int unsigned k;
		total = 0;
		for (k = 0; k < 8; k++)
			total += op_weight[mix][k];
		roll = $urandom_range(0, total - 1);
		for (k = 0; k < 6; k++) begin
			if (roll < op_weight[mix][k])
				return k[bldq_pkg::OPCODE_W-1:0];
			roll -= op_weight[mix][k];
		end
		if (roll < op_weight[mix][6])
			return OP_UNUSED_LO;
		return OP_UNUSED_HI;
	endfunction

	// Mostly values that are already held or shared, so that matches are
	// common. The rest spread over the full 32-bit range.
	function automatic logic signed [31:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return value_pool[$urandom_range(0, 7)];
		if (roll < 70 && list_len > 0)
			return list_mem[$urandom_range(0, list_len - 1)];
		return $urandom();
	endfunction

	initial begin : stimulus
		bldq_pkg::item_t it;
		int unsigned     n;
		int unsigned     p;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table, walked row by row, with no gaps.
		foreach (directed_rows[r]) begin
			it.opcode = directed_rows[r].opcode;
			it.value  = directed_rows[r].value;
			repeat (directed_rows[r].reps)
				send_item(it, directed_rows[r].typed, directed_rows[r].want);
		end
		drain_results();

		// Random phases. Each one starts from whatever list the previous one
		// left, so full and empty lists are met in the middle of traffic.
		for (p = 0; p < NUM_PHASES; p++) begin
			if (p == 2 || p == 4)
				drain_results();
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase_idle_pct[p] != 0 && $urandom_range(0, 99) < phase_idle_pct[p])
					sender_gap($urandom_range(1, 13));
				it.opcode = pick_opcode(phase_mix[p]);
				it.value  = pick_value();
				send_item(it, 1'b0, '0);
			end
		end

		@(negedge clk);
		start       <= 1'b0;
		typed_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		// A few more cycles, so that a stray extra result would be seen.
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("bounded_list_deque_with_delete_core test passed");
		else
			$display("bounded_list_deque_with_delete_core test failed");
		$finish;
	end

endmodule
